// ----- rtl/sync_length_checksum_deframer_defines.svh -----
// assertion macros for the sync/length/checksum deframer
// depends on nothing; expects clk and rst_n in the scope of use
`ifndef SYNC_LENGTH_CHECKSUM_DEFRAMER_DEFINES_SVH
`define SYNC_LENGTH_CHECKSUM_DEFRAMER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked outside reset
`define SLD_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer check failed");

// next-cycle implication, checked outside reset
`define SLD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer check failed");

`else

`define SLD_ASSERT_IMPL(lbl, ante, cons)
`define SLD_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ----- rtl/sld_pkg.sv -----
// shared types and constants of the sync/length/checksum deframer
// depends on nothing
package sld_pkg;

    localparam int unsigned SLD_MAX_HELD_DEFAULT = 255;

    localparam logic [7:0]  SYNC_FIRST    = 8'h4E;   // 'N'
    localparam logic [7:0]  SYNC_SECOND   = 8'h58;   // 'X'
    localparam logic [15:0] MIN_FRAME     = 16'd6;
    localparam logic [31:0] TIMEOUT_RESET = 32'd1000;
    localparam int unsigned HEADER_BYTES  = 4;       // sync pair and length

    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_TICK = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        KIND_BODY   = 2'd0,
        KIND_GOOD   = 2'd1,
        KIND_BADSUM = 2'd2,
        KIND_ABORT  = 2'd3
    } kind_t;

    typedef struct packed {
        logic       operation;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] body_data;
        logic [7:0] body_position;
        logic [7:0] frame_length;
    } result_t;

    // registered input item handed to the frame logic
    typedef struct packed {
        logic     go;
        in_item_t item;
    } step_t;

    // result of one step, valid when the step produces an item
    typedef struct packed {
        logic    valid;
        result_t item;
    } step_result_t;

endpackage

// ----- rtl/sld_stream_if.sv -----
// valid/ready stream channel with a typed payload
// depends on nothing
interface sld_stream_if #(
    parameter type payload_t = logic [7:0]
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/sld_in_stage.sv -----
// input register of the deframer: holds one transfer until the frame logic takes it
// depends on sld_pkg and sld_stream_if
module sld_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    sld_stream_if.sink        byte_stream,
    input  logic              advance,
    output sld_pkg::step_t    step
);
    import sld_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;
    logic     take;

    // free slot or the held item leaves this cycle
    assign byte_stream.ready = !valid_reg || advance;
    assign take              = byte_stream.valid && byte_stream.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= byte_stream.payload;
        end
    end

    assign step.go   = valid_reg && advance;
    assign step.item = item_reg;

endmodule

// ----- rtl/sld_core.sv -----
// frame state and per-byte decode: sync hunt, length, checksum, timeout, buffer limit
// depends on sld_pkg and the assertion macros header
`include "sync_length_checksum_deframer_defines.svh"

module sld_core #(
    parameter int unsigned MAX_HELD_BYTES = sld_pkg::SLD_MAX_HELD_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [31:0]           cfg_data,
    input  sld_pkg::step_t        step,
    output sld_pkg::step_result_t result
);
    import sld_pkg::*;

    localparam int unsigned HW = $clog2(MAX_HELD_BYTES + 1);
    localparam int unsigned CW = (HW + 1 > 16) ? HW + 1 : 16;

    typedef enum logic [1:0] {
        PH_HUNT   = 2'd0,
        PH_GOT_N  = 2'd1,
        PH_LENGTH = 2'd2,
        PH_BODY   = 2'd3
    } phase_t;

    phase_t        phase_reg,   phase_next;
    logic [HW-1:0] held_reg,    held_next;
    logic [15:0]   exp_reg,     exp_next;
    logic [7:0]    sum_reg,     sum_next;
    logic [31:0]   timer_reg,   timer_next;
    logic [31:0]   timeout_reg;

    logic          held_any;
    logic          fresh;
    logic          stop;
    logic [7:0]    b;
    logic [15:0]   full_len;
    step_result_t  res;

    assign b        = step.item.data_byte;
    assign held_any = (held_reg != '0);
    assign full_len = {exp_reg[15:8], b};

    // one step of the frame decoder
    always_comb
    begin
        phase_next = phase_reg;
        held_next  = held_reg;
        exp_next   = exp_reg;
        sum_next   = sum_reg;
        timer_next = timer_reg;
        res        = '0;
        fresh      = !held_any;
        stop       = 1'b0;

        if (step.item.operation == OP_TICK)
        begin
            // timer runs only while bytes are held, saturating
            if (held_any && (timer_reg != '1))
            begin
                timer_next = timer_reg + 32'd1;
            end
        end
        else
        begin
            // timeout or buffer limit aborts what is held
            if (held_any && (timer_reg > timeout_reg))
            begin
                res.valid             = 1'b1;
                res.item.kind         = KIND_ABORT;
                res.item.frame_length = 8'(held_reg);
                fresh                 = 1'b1;
            end
            else if (held_any && (held_reg == HW'(MAX_HELD_BYTES)))
            begin
                res.valid             = 1'b1;
                res.item.kind         = KIND_ABORT;
                res.item.frame_length = 8'(held_reg);
                stop                  = 1'b1;
            end

            if (stop || fresh)
            begin
                phase_next = PH_HUNT;
                held_next  = '0;
                exp_next   = '0;
                sum_next   = '0;
                timer_next = '0;
            end

            if (!stop)
            begin
                if (fresh)
                begin
                    // nothing held: look for the first sync byte
                    if (b == SYNC_FIRST)
                    begin
                        phase_next = PH_GOT_N;
                        held_next  = HW'(1);
                        sum_next   = b;
                    end
                end
                else
                begin
                    unique case (phase_reg)
                        PH_GOT_N:
                        begin
                            if (b == SYNC_SECOND)
                            begin
                                phase_next = PH_LENGTH;
                                held_next  = HW'(2);
                                sum_next   = sum_reg + b;
                            end
                            else if (b == SYNC_FIRST)
                            begin
                                sum_next = b;
                            end
                            else
                            begin
                                phase_next = PH_HUNT;
                                held_next  = '0;
                                exp_next   = '0;
                                sum_next   = '0;
                                timer_next = '0;
                            end
                        end
                        PH_LENGTH:
                        begin
                            sum_next = sum_reg + b;
                            if (held_reg == HW'(2))
                            begin
                                exp_next  = {b, 8'h00};
                                held_next = HW'(3);
                            end
                            else if (full_len < MIN_FRAME)
                            begin
                                // short length drops the frame silently
                                phase_next = PH_HUNT;
                                held_next  = '0;
                                exp_next   = '0;
                                sum_next   = '0;
                                timer_next = '0;
                            end
                            else
                            begin
                                exp_next   = full_len;
                                held_next  = HW'(HEADER_BYTES);
                                phase_next = PH_BODY;
                            end
                        end
                        PH_BODY:
                        begin
                            res.valid = 1'b1;
                            if ((CW'(held_reg) + CW'(1)) >= CW'(exp_reg))
                            begin
                                // last byte carries the checksum
                                res.item.kind         = (b == sum_reg) ? KIND_GOOD : KIND_BADSUM;
                                res.item.frame_length = exp_reg[7:0];
                                phase_next = PH_HUNT;
                                held_next  = '0;
                                exp_next   = '0;
                                sum_next   = '0;
                                timer_next = '0;
                            end
                            else
                            begin
                                res.item.kind          = KIND_BODY;
                                res.item.body_data     = b;
                                res.item.body_position = 8'(held_reg - HW'(HEADER_BYTES));
                                sum_next  = sum_reg + b;
                                held_next = held_reg + HW'(1);
                            end
                        end
                        default:
                        begin
                            phase_next = PH_HUNT;
                            held_next  = '0;
                            exp_next   = '0;
                            sum_next   = '0;
                            timer_next = '0;
                        end
                    endcase
                end
            end
        end
    end

    assign result.valid = step.go && res.valid;
    assign result.item  = res.item;

    // frame state and timeout register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HUNT;
            held_reg    <= '0;
            exp_reg     <= '0;
            sum_reg     <= '0;
            timer_reg   <= '0;
            timeout_reg <= TIMEOUT_RESET;
        end
        else
        begin
            if (step.go)
            begin
                phase_reg <= phase_next;
                held_reg  <= held_next;
                exp_reg   <= exp_next;
                sum_reg   <= sum_next;
                timer_reg <= timer_next;
            end
            if (cfg_we)
            begin
                timeout_reg <= cfg_data;
            end
        end
    end

    // hunting and an empty hold go together
    `SLD_ASSERT_IMPL(a_hunt_empty, phase_reg == PH_HUNT, held_reg == '0)
    `SLD_ASSERT_IMPL(a_held_in_frame, held_reg != '0, phase_reg != PH_HUNT)
    // body phase always has the full header held, within the buffer limit
    `SLD_ASSERT_IMPL(a_body_header, phase_reg == PH_BODY,
        (held_reg >= HW'(HEADER_BYTES)) && (held_reg <= HW'(MAX_HELD_BYTES)))
    // a verdict closes the frame
    `SLD_ASSERT_NEXT(a_verdict_clears, result.valid &&
        (result.item.kind == KIND_GOOD || result.item.kind == KIND_BADSUM),
        phase_reg == PH_HUNT && held_reg == '0)

endmodule

// ----- rtl/sld_out_stage.sv -----
// result register of the deframer: holds one result until the sink takes it
// depends on sld_pkg and sld_stream_if
module sld_out_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sld_pkg::step_result_t result,
    output logic                 can_take,
    sld_stream_if.source         result_stream
);
    import sld_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t item_reg;
    logic    load;

    // empty or emptying this cycle
    assign can_take = !valid_reg || result_stream.ready;
    assign load     = can_take && result.valid;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (result_stream.ready)
        begin
            valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= result.item;
        end
    end

    assign result_stream.valid   = valid_reg;
    assign result_stream.payload = item_reg;

endmodule

// ----- rtl/sync_length_checksum_deframer.sv -----
// top level of the sync/length/checksum deframer
// depends on sld_pkg, sld_stream_if, sld_in_stage, sld_core, sld_out_stage
//
//  channel        | role   | payload
//  ---------------+--------+-------------------------------------------------
//  byte_stream    | sink   | operation, data_byte
//  result_stream  | source | kind, body_data, body_position, frame_length
//  cfg_we/cfg_data| write  | timeout_ticks
//
// one transfer per cycle while the result stream keeps up; an input transfer passes
// the input register, then the frame logic into the result register.
// reset clears the frame state and sets timeout_ticks to 1000; no clearing pass.
// a stalled result stream holds the result register and backs up into the
// input register, which then drops ready; ticks pass the frame logic but give no result.
module sync_length_checksum_deframer #(
    parameter int unsigned MAX_HELD_BYTES = sld_pkg::SLD_MAX_HELD_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [31:0]  cfg_data,
    sld_stream_if.sink   byte_stream,
    sld_stream_if.source result_stream
);
    import sld_pkg::*;

    step_t        step;
    step_result_t result;
    logic         advance;

    // input register
    sld_in_stage u_in (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_stream (byte_stream),
        .advance     (advance),
        .step        (step)
    );

    // frame decoder
    sld_core #(
        .MAX_HELD_BYTES (MAX_HELD_BYTES)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .step     (step),
        .result   (result)
    );

    // result register
    sld_out_stage u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .result        (result),
        .can_take      (advance),
        .result_stream (result_stream)
    );

endmodule

// ----- tb/sv/sync_length_checksum_deframer_tb.sv -----
`timescale 1ns / 1ps
// self-checking testbench for the sync/length/checksum deframer
// depends on sld_pkg, sld_stream_if and the sync_length_checksum_deframer rtl
module sync_length_checksum_deframer_tb;
    import sld_pkg::*;

    localparam int unsigned MAX_HELD     = SLD_MAX_HELD_DEFAULT;
    localparam int unsigned SETTLE_LAT   = 8;
    localparam int unsigned HOLD_CYCLES  = 150;
    localparam int unsigned PHASE_ITEMS  = 440;

    typedef enum logic [1:0] {
        HUNT_SYNC,
        HAVE_N,
        READ_LENGTH,
        READ_BODY
    } deframe_phase_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we;
    logic [31:0] cfg_data;
    logic        long_hold;

    sld_stream_if #(.payload_t(in_item_t)) byte_if ();
    sld_stream_if #(.payload_t(result_t))  result_if ();

    sync_length_checksum_deframer #(
        .MAX_HELD_BYTES(MAX_HELD)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .byte_stream  (byte_if),
        .result_stream(result_if)
    );

    // clock
    always #2 clk = ~clk;

    // predictor state and configuration
    deframe_phase_t deframe_phase;
    int unsigned    held_bytes;
    logic [15:0]    frame_len;
    logic [7:0]     byte_sum;
    logic [31:0]    idle_ticks;
    logic [31:0]    timeout_limit;

    // stimulus and scoreboard storage
    in_item_t    pending_items[$];
    result_t     expected_results[$];
    int unsigned queued_items;
    int unsigned accepted_items;
    int unsigned tick_items;
    int unsigned kind_seen[4];
    int unsigned error_count;
    int unsigned tick_pct;
    logic [31:0] small_timeout;
    logic [31:0] random_timeout;

    // handshake pacing
    int unsigned send_wait;
    int unsigned send_calm;
    int unsigned recv_wait;
    int unsigned recv_calm;

    function automatic void clear_frame_state();
        deframe_phase = HUNT_SYNC;
        held_bytes    = 0;
        frame_len     = '0;
        byte_sum      = '0;
        idle_ticks    = '0;
    endfunction

    // advance the deframer by one item, returns 1 when a result comes out
    function automatic bit deframe_step(input in_item_t item, output result_t res);
        logic [7:0] b;
        bit         produced;
        b        = item.data_byte;
        produced = 1'b0;
        res      = '0;
        if (item.operation == OP_TICK) begin
            if (held_bytes > 0 && idle_ticks != '1)
                idle_ticks++;
            return 1'b0;
        end

        // inactivity timeout, then the byte is looked at afresh
        if (held_bytes > 0 && idle_ticks > timeout_limit) begin
            res.kind         = KIND_ABORT;
            res.frame_length = 8'(held_bytes);
            produced         = 1'b1;
            clear_frame_state();
        end
        // buffer would overflow, byte is dropped
        else if (held_bytes > 0 && held_bytes + 1 > MAX_HELD) begin
            res.kind         = KIND_ABORT;
            res.frame_length = 8'(held_bytes);
            clear_frame_state();
            return 1'b1;
        end

        if (held_bytes == 0) begin
            clear_frame_state();
            if (b == SYNC_FIRST) begin
                deframe_phase = HAVE_N;
                held_bytes    = 1;
                byte_sum      = b;
            end
            return produced;
        end

        case (deframe_phase)
            HAVE_N:
            begin
                if (b == SYNC_SECOND) begin
                    deframe_phase = READ_LENGTH;
                    held_bytes    = 2;
                    byte_sum      = byte_sum + b;
                end else if (b == SYNC_FIRST) begin
                    byte_sum = b;
                end else begin
                    clear_frame_state();
                end
            end
            READ_LENGTH:
            begin
                byte_sum = byte_sum + b;
                if (held_bytes == 2) begin
                    frame_len  = {b, 8'h00};
                    held_bytes = 3;
                end else begin
                    frame_len  = {frame_len[15:8], b};
                    held_bytes = 4;
                    if (frame_len < MIN_FRAME)
                        clear_frame_state();
                    else
                        deframe_phase = READ_BODY;
                end
            end
            READ_BODY:
            begin
                if (held_bytes + 1 >= frame_len) begin
                    if (b == byte_sum)
                        res.kind = KIND_GOOD;
                    else
                        res.kind = KIND_BADSUM;
                    res.frame_length = frame_len[7:0];
                    produced         = 1'b1;
                    clear_frame_state();
                end else begin
                    res.kind          = KIND_BODY;
                    res.body_data     = b;
                    res.body_position = 8'(held_bytes - HEADER_BYTES);
                    produced          = 1'b1;
                    byte_sum          = byte_sum + b;
                    held_bytes++;
                end
            end
            default:
            begin
                clear_frame_state();
            end
        endcase
        return produced;
    endfunction

    // wait before the next transfer, with runs of back-to-back transfers
    function automatic int unsigned draw_wait(inout int unsigned calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
            calm_left = $urandom_range(20, 60);
        return $urandom_range(0, 19);
    endfunction

    function automatic void note_failure(input string msg);
        error_count++;
        if (error_count <= 10)
            $display("%0t ns  mismatch: %s", $time, msg);
    endfunction

    // byte driver: offers queued items, predicts on each accepted transfer
    always @(posedge clk or negedge rst_n)
    begin
        result_t predicted;
        if (!rst_n) begin
            byte_if.valid   <= 1'b0;
            byte_if.payload <= '0;
            send_wait = 0;
            send_calm = 0;
        end else begin
            if (byte_if.valid && byte_if.ready) begin
                accepted_items++;
                if (byte_if.payload.operation == OP_TICK)
                    tick_items++;
                if (deframe_step(byte_if.payload, predicted)) begin
                    expected_results = {expected_results, predicted};
                    kind_seen[predicted.kind]++;
                end
                send_wait = draw_wait(send_calm);
            end
            if (byte_if.valid && !byte_if.ready) begin
                // hold the offered item until it is taken
            end else if (send_wait > 0) begin
                send_wait--;
                byte_if.valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                byte_if.valid   <= 1'b1;
                byte_if.payload <= pending_items.pop_front();
            end else begin
                byte_if.valid <= 1'b0;
            end
        end
    end

    // result monitor: compares each transfer with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        result_t got;
        result_t want;
        if (!rst_n) begin
            result_if.ready <= 1'b0;
            recv_wait = 0;
            recv_calm = 0;
        end else begin
            if (result_if.valid && result_if.ready) begin
                got = result_if.payload;
                if (expected_results.size() == 0) begin
                    note_failure($sformatf("unexpected result kind %0d data %0d pos %0d len %0d",
                                           got.kind, got.body_data, got.body_position,
                                           got.frame_length));
                end else begin
                    want = expected_results.pop_front();
                    if (got.kind !== want.kind || got.body_data !== want.body_data ||
                        got.body_position !== want.body_position ||
                        got.frame_length !== want.frame_length)
                        note_failure($sformatf(
                            "expected kind %0d data %0d pos %0d len %0d, got %0d %0d %0d %0d",
                            want.kind, want.body_data, want.body_position, want.frame_length,
                            got.kind, got.body_data, got.body_position, got.frame_length));
                end
                recv_wait = draw_wait(recv_calm);
            end
            if (long_hold) begin
                result_if.ready <= 1'b0;
            end else if (recv_wait > 0) begin
                recv_wait--;
                result_if.ready <= 1'b0;
            end else begin
                result_if.ready <= 1'b1;
            end
        end
    end

    // long receiver stalls so the block backs up into its input
    initial
    begin
        int unsigned k;
        long_hold = 1'b0;
        for (k = 0; k < 2; k++) begin
            while (accepted_items < 500 + k * 800)
                @(posedge clk);
            long_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            long_hold <= 1'b0;
        end
    end

    task automatic push_item(input op_t op, input logic [7:0] data);
        in_item_t entry;
        entry.operation = op;
        entry.data_byte = data;
        pending_items   = {pending_items, entry};
        queued_items++;
    endtask

    // one received byte, sometimes preceded by a few ticks
    task automatic add_byte(input logic [7:0] b);
        if (tick_pct > 0 && $urandom_range(0, 99) < tick_pct)
            repeat ($urandom_range(1, 3)) push_item(OP_TICK, 8'($urandom));
        push_item(OP_BYTE, b);
    endtask

    // header, body with checksum, optionally cut short after keep bytes
    task automatic add_frame(input logic [15:0] flen, input bit corrupt,
                             input int unsigned keep);
        logic [7:0]  frame_bytes[$];
        logic [7:0]  sum;
        int unsigned nbody;
        int unsigned i;
        frame_bytes = '{SYNC_FIRST, SYNC_SECOND, flen[15:8], flen[7:0]};
        if (flen < MIN_FRAME)
            nbody = 0;
        else if (flen > MAX_HELD)
            nbody = MAX_HELD - HEADER_BYTES + 1;
        else
            nbody = flen - HEADER_BYTES;
        for (i = 0; i < nbody; i++)
            frame_bytes = {frame_bytes, 8'($urandom)};
        if (flen >= MIN_FRAME && flen <= MAX_HELD) begin
            sum = '0;
            for (i = 0; i + 1 < frame_bytes.size(); i++)
                sum = sum + frame_bytes[i];
            frame_bytes[$] = corrupt ? sum + 8'($urandom_range(1, 255)) : sum;
        end
        while (frame_bytes.size() > keep)
            void'(frame_bytes.pop_back());
        foreach (frame_bytes[j])
            add_byte(frame_bytes[j]);
    endtask

    // mostly well-formed frames, the rest short lengths, noise, broken syncs and tick runs
    task automatic add_random(input int unsigned count);
        int unsigned start;
        int unsigned pick;
        int unsigned k;
        logic [15:0] flen;
        start = queued_items;
        while (queued_items - start < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 68) begin
                k = $urandom_range(0, 79);
                if (k == 0)
                    flen = 16'(MAX_HELD);
                else if (k == 1)
                    flen = 16'($urandom_range(MAX_HELD + 1, 65535));
                else
                    flen = 16'($urandom_range(6, 20));
                add_frame(flen, $urandom_range(0, 3) == 0,
                          ($urandom_range(0, 9) == 0) ? $urandom_range(1, 8) : 1000);
            end else if (pick < 76) begin
                add_frame(16'($urandom_range(0, 5)), 1'b0, 1000);
            end else if (pick < 84) begin
                add_byte(SYNC_FIRST);
                add_byte($urandom_range(0, 1) ? SYNC_FIRST : 8'($urandom));
            end else if (pick < 94) begin
                repeat ($urandom_range(1, 5)) add_byte(8'($urandom));
            end else begin
                repeat ($urandom_range(1, 8)) push_item(OP_TICK, 8'($urandom));
            end
        end
    endtask

    // idle: every item taken, every result seen, pipeline settled
    task automatic wait_drained();
        while (!(pending_items.size() == 0 && accepted_items == queued_items &&
                 expected_results.size() == 0))
            @(posedge clk);
        repeat (SETTLE_LAT) @(posedge clk);
    endtask

    task automatic set_timeout(input logic [31:0] ticks);
        @(posedge clk);
        cfg_we        <= 1'b1;
        cfg_data      <= ticks;
        timeout_limit = ticks;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // stimulus sequence
    initial
    begin
        byte_if.valid   = 1'b0;
        byte_if.payload = '0;
        result_if.ready = 1'b0;
        cfg_we          = 1'b0;
        cfg_data        = '0;
        queued_items    = 0;
        accepted_items  = 0;
        tick_items      = 0;
        error_count     = 0;
        kind_seen       = '{default: 0};
        tick_pct        = 0;
        timeout_limit   = TIMEOUT_RESET;
        clear_frame_state();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset timeout, tick while idle, noise, good and bad frames,
        // broken sync, repeated 'N' followed by a too-short length
        push_item(OP_TICK, 8'hFF);
        add_byte(8'h00);
        add_byte(8'hFF);
        add_frame(16'd6, 1'b0, 1000);
        add_frame(16'd7, 1'b1, 1000);
        add_byte(SYNC_FIRST);
        add_byte(8'h41);
        add_byte(SYNC_FIRST);
        add_frame(16'd5, 1'b0, 1000);
        wait_drained();

        // shortest timeout: abort on late byte that restarts a frame,
        // then the longest frame and a buffer overflow
        set_timeout(32'd1);
        add_byte(SYNC_FIRST);
        add_byte(SYNC_SECOND);
        push_item(OP_TICK, 8'h00);
        push_item(OP_TICK, 8'h00);
        add_frame(16'd6, 1'b0, 1000);
        add_frame(16'(MAX_HELD), 1'b0, 1000);
        add_frame(16'hFFFF, 1'b0, 1000);
        tick_pct = 10;
        add_random(PHASE_ITEMS);
        wait_drained();

        small_timeout = $urandom_range(2, 6);
        set_timeout(small_timeout);
        add_random(PHASE_ITEMS);
        wait_drained();

        set_timeout(32'hFFFF_FFFF);
        add_random(PHASE_ITEMS);
        wait_drained();

        random_timeout = $urandom | 32'h1;
        tick_pct = 5;
        set_timeout(random_timeout);
        add_random(PHASE_ITEMS);
        wait_drained();

        if (expected_results.size() > 0)
            note_failure($sformatf("%0d results never arrived", expected_results.size()));
        $display("run covered %0d input transfers (%0d ticks), timeouts 1000, 1, %0d, max, %0d",
                 accepted_items, tick_items, small_timeout, random_timeout);
        $display("results seen: %0d body bytes, %0d good, %0d bad checksum, %0d aborted",
                 kind_seen[KIND_BODY], kind_seen[KIND_GOOD], kind_seen[KIND_BADSUM],
                 kind_seen[KIND_ABORT]);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // watchdog
    initial
    begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
